[hdl/rdm_pkg.sv]
// ----------------------------------------------------------------------------
// RDM discovery responder package
// Shared codes, the queue entry type and the discovery response encoder.
// ----------------------------------------------------------------------------
package rdm_pkg;

   localparam int UID_W       = 48;
   localparam int BYTE_IDX_W  = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0]  DISC_CLASS        = 8'h10;
   localparam logic [15:0] PID_UNIQUE_BRANCH = 16'h0001;
   localparam logic [15:0] PID_MUTE          = 16'h0002;
   localparam logic [15:0] PID_UN_MUTE       = 16'h0003;
   localparam logic [15:0] SUB_DEVICE_FLAG   = 16'h0002;
   localparam logic [15:0] CHECKSUM_SEED     = 16'h05FA;

   localparam logic [2:0] KIND_IGNORED    = 3'd0;
   localparam logic [2:0] KIND_DISC_BYTE  = 3'd1;
   localparam logic [2:0] KIND_MUTE_ACK   = 3'd2;
   localparam logic [2:0] KIND_UNMUTE_ACK = 3'd3;
   localparam logic [2:0] KIND_PASS_ON    = 3'd4;
   localparam logic [2:0] KIND_DROPPED    = 3'd5;

   localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = 5'd23;
   localparam logic [BYTE_IDX_W-1:0] PREAMBLE_END  = 5'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] control;
      logic        group;
      logic        muted;
   } desc_type;

   function automatic logic [15:0] uid_checksum(input logic [UID_W-1:0] uid);
      logic [15:0] sum;
      sum = CHECKSUM_SEED
          + {8'h00, uid[47:40]} + {8'h00, uid[39:32]} + {8'h00, uid[31:24]}
          + {8'h00, uid[23:16]} + {8'h00, uid[15:8]}  + {8'h00, uid[7:0]};
      return sum;
   endfunction

   function automatic logic [7:0] response_byte(input logic [UID_W-1:0] uid,
                                                input logic [15:0] sum,
                                                input logic [BYTE_IDX_W-1:0] idx);
      logic [7:0]            mask;
      logic [7:0]            raw;
      logic [BYTE_IDX_W-2:0] pair;
      mask = idx[0] ? 8'h55 : 8'hAA;
      pair = idx[BYTE_IDX_W-1:1];
      case (pair)
         4'd4:    raw = uid[47:40];
         4'd5:    raw = uid[39:32];
         4'd6:    raw = uid[31:24];
         4'd7:    raw = uid[23:16];
         4'd8:    raw = uid[15:8];
         4'd9:    raw = uid[7:0];
         4'd10:   raw = sum[15:8];
         default: raw = sum[7:0];
      endcase
      if (idx < PREAMBLE_END) begin
         return 8'hFE;
      end else if (idx == PREAMBLE_END) begin
         return 8'hAA;
      end else begin
         return raw | mask;
      end
   endfunction

endpackage

[hdl/rdm_front.sv]
// ----------------------------------------------------------------------------
// RDM request classifier
// Accepts request headers, decodes the destination, keeps the discovery mute
// flag and pushes one result descriptor per request into the queue.
// ----------------------------------------------------------------------------
module rdm_front
   import rdm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [UID_W-1:0] req_dest_uid,
   input  logic [7:0]       req_cmd_class,
   input  logic [15:0]      req_pid,
   input  logic [7:0]       req_param_length,
   input  logic [UID_W-1:0] req_lower_bound_uid,
   input  logic [UID_W-1:0] req_upper_bound_uid,
   input  logic [UID_W-1:0] device_uid,
   input  logic             has_sub_devices,
   input  logic             queue_full,
   output logic             push,
   output desc_type         push_desc
);

   logic muted_ff, muted_in;
   logic bcast, vcast, for_me, in_range;
   logic is_mute_pid;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign bcast  = (req_dest_uid == {UID_W{1'b1}});
   assign vcast  = (req_dest_uid[47:32] == device_uid[47:32]) &&
                   (req_dest_uid[31:0] == 32'hFFFF_FFFF);
   assign for_me = vcast || (req_dest_uid == device_uid);
   assign in_range = (req_lower_bound_uid <= device_uid) &&
                     (device_uid <= req_upper_bound_uid);
   assign is_mute_pid = (req_pid == PID_MUTE) || (req_pid == PID_UN_MUTE);

   always_comb begin
      muted_in          = muted_ff;
      push_desc.kind    = KIND_IGNORED;
      push_desc.control = 16'h0000;
      push_desc.group   = 1'b0;
      if (!for_me && !bcast) begin
         push_desc.kind = KIND_IGNORED;
      end else if (req_cmd_class != DISC_CLASS) begin
         push_desc.kind  = KIND_PASS_ON;
         push_desc.group = bcast || vcast;
      end else if (req_pid == PID_UNIQUE_BRANCH) begin
         if (!muted_ff && in_range) begin
            push_desc.kind = KIND_DISC_BYTE;
         end
      end else if (is_mute_pid) begin
         if (req_param_length != 8'h00) begin
            push_desc.kind = KIND_DROPPED;
         end else begin
            muted_in = (req_pid == PID_MUTE);
            if (for_me) begin
               push_desc.kind    = (req_pid == PID_MUTE) ? KIND_MUTE_ACK
                                                         : KIND_UNMUTE_ACK;
               push_desc.control = has_sub_devices ? SUB_DEVICE_FLAG : 16'h0000;
            end
         end
      end
      push_desc.muted = muted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         muted_ff <= 1'b0;
      end else if (push) begin
         muted_ff <= muted_in;
      end
   end

endmodule

[hdl/rdm_queue.sv]
// ----------------------------------------------------------------------------
// RDM descriptor queue
// Short first-in first-out queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module rdm_queue
   import rdm_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output desc_type head_desc,
   output logic     empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   desc_type            entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign empty     = (count_ff == '0);
   assign head_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

[hdl/rdm_back.sv]
// ----------------------------------------------------------------------------
// RDM result emitter
// Turns queued descriptors into result items, expanding a discovery answer
// into its encoded response bytes, and holds the output register.
// ----------------------------------------------------------------------------
module rdm_back
   import rdm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  desc_type         head_desc,
   input  logic             empty,
   output logic             pop,
   input  logic [UID_W-1:0] device_uid,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_result_kind,
   output logic [7:0]       rsp_response_byte,
   output logic [15:0]      rsp_control_field,
   output logic             rsp_group_addressed,
   output logic             rsp_muted_now,
   output logic             rsp_is_last
);

   logic                  valid_ff;
   logic [2:0]            kind_ff;
   logic [7:0]            byte_ff, byte_in;
   logic [15:0]           control_ff;
   logic                  group_ff, muted_ff, last_ff, last_in;
   logic [BYTE_IDX_W-1:0] idx_ff;
   logic                  load, is_disc;
   logic [15:0]           checksum;

   assign load     = !empty && (!valid_ff || !rsp_stall);
   assign is_disc  = (head_desc.kind == KIND_DISC_BYTE);
   assign last_in  = !is_disc || (idx_ff == LAST_BYTE_IDX);
   assign pop      = load && last_in;
   assign checksum = uid_checksum(device_uid);
   assign byte_in  = is_disc ? response_byte(device_uid, checksum, idx_ff) : 8'h00;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= last_in ? '0 : idx_ff + 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= head_desc.kind;
         byte_ff    <= byte_in;
         control_ff <= head_desc.control;
         group_ff   <= head_desc.group;
         muted_ff   <= head_desc.muted;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_response_byte   = byte_ff;
   assign rsp_control_field   = control_ff;
   assign rsp_group_addressed = group_ff;
   assign rsp_muted_now       = muted_ff;
   assign rsp_is_last         = last_ff;

endmodule

[hdl/rdm_discovery_responder.sv]
// ----------------------------------------------------------------------------
// RDM discovery responder
// Classifies decoded request headers by destination and answers discovery.
// ----------------------------------------------------------------------------
// The first result item of a request passes through the descriptor queue
// and the output register before it is shown. The emitter gives one result
// item per cycle while the output is not stalled: a unique branch answer is
// 24 response bytes, any other request one; the classifier takes one item
// per cycle while the queue has room. Synchronous reset clears the mute flag,
// queue, valid flag and configuration registers to zero, not the output data.
// ----------------------------------------------------------------------------
module rdm_discovery_responder
   import rdm_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [UID_W-1:0] csr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [UID_W-1:0] req_dest_uid,
   input  logic [7:0]       req_cmd_class,
   input  logic [15:0]      req_pid,
   input  logic [7:0]       req_param_length,
   input  logic [UID_W-1:0] req_lower_bound_uid,
   input  logic [UID_W-1:0] req_upper_bound_uid,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_result_kind,
   output logic [7:0]       rsp_response_byte,
   output logic [15:0]      rsp_control_field,
   output logic             rsp_group_addressed,
   output logic             rsp_muted_now,
   output logic             rsp_is_last
);

   logic [UID_W-1:0] device_uid_ff;
   logic             sub_devices_ff;
   logic             push, pop, queue_full, queue_empty;
   desc_type         push_desc, head_desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_uid_ff  <= '0;
         sub_devices_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_index == 1'b0) begin
            device_uid_ff <= csr_data;
         end else begin
            sub_devices_ff <= csr_data[0];
         end
      end
   end

   rdm_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_dest_uid        (req_dest_uid),
      .req_cmd_class       (req_cmd_class),
      .req_pid             (req_pid),
      .req_param_length    (req_param_length),
      .req_lower_bound_uid (req_lower_bound_uid),
      .req_upper_bound_uid (req_upper_bound_uid),
      .device_uid          (device_uid_ff),
      .has_sub_devices     (sub_devices_ff),
      .queue_full          (queue_full),
      .push                (push),
      .push_desc           (push_desc)
   );

   rdm_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (pop),
      .head_desc (head_desc),
      .empty     (queue_empty)
   );

   rdm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_desc           (head_desc),
      .empty               (queue_empty),
      .pop                 (pop),
      .device_uid          (device_uid_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_response_byte   (rsp_response_byte),
      .rsp_control_field   (rsp_control_field),
      .rsp_group_addressed (rsp_group_addressed),
      .rsp_muted_now       (rsp_muted_now),
      .rsp_is_last         (rsp_is_last)
   );

endmodule
